>>> hw/rtl/iptr_pkg.sv
// Shared constants, codes and controller/datapath interface types of the neighbour table resolver.
package iptr_pkg;

    localparam int IP_W      = 32;
    localparam int MAC_W     = 48;
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SUBNET_MASK = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GATEWAY_IP  = 8'd1;

    // Request actions.
    localparam logic ACT_LEARN   = 1'b0;
    localparam logic ACT_RESOLVE = 1'b1;

    localparam logic [IP_W-1:0]  SUBNET_MASK_RST = 32'hFFFF_FF00;
    localparam logic [IP_W-1:0]  GATEWAY_IP_RST  = 32'h0000_0000;
    localparam logic [IP_W-1:0]  BCAST_IP        = 32'hFFFF_FFFF;
    localparam logic [MAC_W-1:0] BCAST_MAC       = 48'hFFFF_FFFF_FFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture a new request and restart the search
        logic step;    // advance the table search by one entry
        logic commit;  // write back the table and load the result register
    } iptr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic search_done;  // search finished, match or end of valid entries
        logic out_free;     // result register can take a new result this cycle
    } iptr_status_t;

endpackage

>>> hw/rtl/iptr_ctrl.sv
// Controller state machine that sequences capture, search and write-back of one request.
module iptr_ctrl
    import iptr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  iptr_status_t status,
    output iptr_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                cmd.step = 1'b1;
                if (status.search_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/iptr_dp.sv
// Datapath holding the neighbour table, configuration registers, search pipeline and result register.
module iptr_dp
    import iptr_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  iptr_cmd_t            cmd,
    output iptr_status_t         status,
    input  logic                 s_action,
    input  logic [IP_W-1:0]      s_ip_addr,
    input  logic [MAC_W-1:0]     s_mac_addr,
    input  logic                 cfg_wr,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [IP_W-1:0]      cfg_data,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic                 m_hit,
    output logic [IP_W-1:0]      m_next_hop,
    output logic [MAC_W-1:0]     m_mac_out,
    output logic                 m_table_full
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    // Entry 0 is the fixed broadcast mapping; its address never changes, so
    // only its MAC is held in a register. Slot 0 of the memories is unused.
    logic [IP_W-1:0]  mem_ip  [ENTRIES];
    logic [MAC_W-1:0] mem_mac [ENTRIES];

    logic [IP_W-1:0]  subnet_mask_reg, subnet_mask_next;
    logic [IP_W-1:0]  gateway_ip_reg, gateway_ip_next;
    logic [MAC_W-1:0] mac0_reg, mac0_next;
    logic [CNT_W-1:0] used_count_reg, used_count_next;

    logic             req_action_reg;
    logic [IP_W-1:0]  req_ip_reg;
    logic [MAC_W-1:0] req_mac_reg;
    logic [IP_W-1:0]  hop_reg;

    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic [IP_W-1:0]  rd_ip_reg;
    logic [MAC_W-1:0] rd_mac_reg;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] found_idx_reg;
    logic [MAC_W-1:0] found_mac_reg;

    logic             out_valid_reg, out_valid_next;
    logic             out_hit_reg;
    logic [IP_W-1:0]  out_hop_reg;
    logic [MAC_W-1:0] out_mac_reg;
    logic             out_full_reg;

    logic             issue;
    logic             match;
    logic [IP_W-1:0]  cmp_ip;
    logic [MAC_W-1:0] cmp_mac;
    logic [IP_W-1:0]  route_hop;
    logic             is_learn;
    logic             tbl_full;
    logic             wr_ip_en;
    logic             wr_mac_en;
    logic [IDX_W-1:0] wr_addr;
    logic             res_hit;
    logic [MAC_W-1:0] res_mac;

    // Routing: off-subnet destinations of a resolve go to the gateway.
    assign route_hop = ((s_action == ACT_RESOLVE) &&
                        ((s_ip_addr & subnet_mask_reg) != (gateway_ip_reg & subnet_mask_reg)))
                       ? gateway_ip_reg : s_ip_addr;

    // Search: one read issued per cycle, compared in the cycle after it is issued.
    assign issue   = cmd.step && !found_reg && (rd_idx_reg < used_count_reg);
    assign cmp_ip  = (cmp_idx_reg == '0) ? BCAST_IP : rd_ip_reg;
    assign cmp_mac = (cmp_idx_reg == '0) ? mac0_reg : rd_mac_reg;
    assign match   = cmp_valid_reg && !found_reg && (cmp_ip == hop_reg);

    assign status.search_done = !cmp_valid_reg &&
                                (found_reg || (rd_idx_reg >= used_count_reg));
    assign status.out_free    = !out_valid_reg || m_ready;

    assign is_learn  = (req_action_reg == ACT_LEARN);
    assign tbl_full  = (used_count_reg == CNT_FULL);
    assign res_hit   = found_reg;
    assign res_mac   = found_reg ? (is_learn ? req_mac_reg : found_mac_reg) : '0;

    // Write-back of a learn: update a found entry or, unless the table is full, append at the fill count.
    always_comb begin
        wr_ip_en  = 1'b0;
        wr_mac_en = 1'b0;
        wr_addr   = used_count_reg[IDX_W-1:0];
        mac0_next = mac0_reg;
        used_count_next = used_count_reg;
        if (cmd.commit && is_learn) begin
            if (found_reg) begin
                if (found_idx_reg == '0) begin
                    mac0_next = req_mac_reg;
                end else begin
                    wr_mac_en = 1'b1;
                    wr_addr   = found_idx_reg;
                end
            end else if (!tbl_full) begin
                wr_ip_en        = 1'b1;
                wr_mac_en       = 1'b1;
                used_count_next = used_count_reg + CNT_ONE;
            end
        end
    end

    always_comb begin
        rd_idx_next    = rd_idx_reg;
        cmp_valid_next = issue;
        found_next     = found_reg || match;
        if (issue) begin
            rd_idx_next = rd_idx_reg + CNT_ONE;
        end
        if (cmd.load) begin
            rd_idx_next    = '0;
            cmp_valid_next = 1'b0;
            found_next     = 1'b0;
        end
    end

    always_comb begin
        subnet_mask_next = subnet_mask_reg;
        gateway_ip_next  = gateway_ip_reg;
        if (cfg_wr) begin
            case (cfg_index)
                REG_SUBNET_MASK: subnet_mask_next = cfg_data;
                REG_GATEWAY_IP:  gateway_ip_next  = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            subnet_mask_reg <= SUBNET_MASK_RST;
            gateway_ip_reg  <= GATEWAY_IP_RST;
            mac0_reg        <= BCAST_MAC;
            used_count_reg  <= CNT_ONE;
            rd_idx_reg      <= '0;
            cmp_valid_reg   <= 1'b0;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            subnet_mask_reg <= subnet_mask_next;
            gateway_ip_reg  <= gateway_ip_next;
            mac0_reg        <= mac0_next;
            used_count_reg  <= used_count_next;
            rd_idx_reg      <= rd_idx_next;
            cmp_valid_reg   <= cmp_valid_next;
            found_reg       <= found_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_action_reg <= s_action;
            req_ip_reg     <= s_ip_addr;
            req_mac_reg    <= s_mac_addr;
            hop_reg        <= route_hop;
        end
        if (issue) begin
            cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];
        end
        if (match) begin
            found_idx_reg <= cmp_idx_reg;
            found_mac_reg <= cmp_mac;
        end
        if (cmd.commit) begin
            out_hit_reg  <= res_hit;
            out_hop_reg  <= hop_reg;
            out_mac_reg  <= res_mac;
            out_full_reg <= is_learn && !found_reg && tbl_full;
        end
    end

    // Table memories: one write port and one registered read port each.
    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_ip_reg  <= mem_ip[rd_idx_reg[IDX_W-1:0]];
            rd_mac_reg <= mem_mac[rd_idx_reg[IDX_W-1:0]];
        end
        if (wr_ip_en) begin
            mem_ip[wr_addr] <= req_ip_reg;
        end
        if (wr_mac_en) begin
            mem_mac[wr_addr] <= req_mac_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_hit        = out_hit_reg;
    assign m_next_hop   = out_hop_reg;
    assign m_mac_out    = out_mac_reg;
    assign m_table_full = out_full_reg;

`ifndef SYNTHESIS
    a_used_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (used_count_reg >= CNT_ONE) && (used_count_reg <= CNT_FULL))
        else $error("fill count left its legal range");

    a_found_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> (CNT_W'(found_idx_reg) < used_count_reg))
        else $error("match recorded beyond the valid entries");

    a_full_excludes_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_full_reg && out_hit_reg))
        else $error("result reports both a hit and a full table");

    a_commit_loads_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> out_valid_reg)
        else $error("write-back did not present a result");

    a_no_commit_mid_search: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> status.search_done)
        else $error("write-back issued before the search finished");
`endif

endmodule

>>> hw/rtl/ip_neighbor_table_resolver_top.sv
// Top level of the IPv4 neighbour table resolver: controller plus datapath.
//
//  Channel   Ports                                          Carries
//  -------   --------------------------------------------   --------------------------------
//  input     s_valid s_ready s_action s_ip_addr s_mac_addr   one learn or resolve request
//  result    m_valid m_ready m_hit m_next_hop m_mac_out      one result per request
//            m_table_full
//  config    cfg_valid cfg_ready cfg_index cfg_data          register writes (mask, gateway)
//
// After acceptance a request reads the valid entries in order through the registered
// read port and compares each, stopping at the first match; once the end of the search
// is seen, the result is written back and loaded into the result register.
// Requests are taken one at a time; s_ready is high only while idle, the cycle after
// the result is loaded. A stalled result holds the next write-back, not the next request.
// Reset is synchronous and active low; it leaves entry 0 mapping broadcast to broadcast.
module ip_neighbor_table_resolver_top
    import iptr_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_action,
    input  logic [IP_W-1:0]      s_ip_addr,
    input  logic [MAC_W-1:0]     s_mac_addr,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_hit,
    output logic [IP_W-1:0]      m_next_hop,
    output logic [MAC_W-1:0]     m_mac_out,
    output logic                 m_table_full,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [IP_W-1:0]      cfg_data
);

    iptr_cmd_t    cmd;
    iptr_status_t status;

    // Configuration writes are always taken; the user must issue them only while idle (not enforced).
    assign cfg_ready = 1'b1;

    iptr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    iptr_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_action     (s_action),
        .s_ip_addr    (s_ip_addr),
        .s_mac_addr   (s_mac_addr),
        .cfg_wr       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_hit        (m_hit),
        .m_next_hop   (m_next_hop),
        .m_mac_out    (m_mac_out),
        .m_table_full (m_table_full)
    );

endmodule

>>> verif/ip_neighbor_table_resolver_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the IPv4 neighbour table resolver with its own table predictor.
module ip_neighbor_table_resolver_top_test
    import iptr_pkg::*;
;

    // The table depth used by both the block and the predictor.
    localparam int TABLE_DEPTH = 16;
    // Settling time allowed after the last result so that the block can go idle.
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;
    // A slow but correct run stays far below this many clock cycles.
    localparam longint CYCLE_LIMIT = 600000;
    // Writes to this index and above must leave both registers unchanged.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_BASE = 8'd2;
    localparam int PHASES = 7;
    localparam int PHASE_REQUESTS = 98;
    localparam int POOL_SIZE = 24;

    // One result as the block reports it.
    typedef struct packed {
        logic             hit;
        logic [IP_W-1:0]  next_hop;
        logic [MAC_W-1:0] mac_out;
        logic             table_full;
    } resolution_t;

    // Keeps a copy of the neighbour table and the routing registers, works out
    // the result of every accepted request, and checks the results in order.
    class resolution_book;
        logic [IP_W-1:0]  ip_tab [TABLE_DEPTH];
        logic [MAC_W-1:0] mac_tab [TABLE_DEPTH];
        int               in_use;
        logic [IP_W-1:0]  mask;
        logic [IP_W-1:0]  gateway;
        resolution_t      awaited [$];
        int               failures;

        function new();
            ip_tab[0]  = BCAST_IP;
            mac_tab[0] = BCAST_MAC;
            in_use     = 1;
            mask       = SUBNET_MASK_RST;
            gateway    = GATEWAY_IP_RST;
            failures   = 0;
        endfunction

        // The first valid slot holding addr, or -1.
        function int find_slot(logic [IP_W-1:0] addr);
            for (int i = 0; i < in_use; i++) begin
                if (ip_tab[i] == addr) return i;
            end
            return -1;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [IP_W-1:0] data);
            if (idx == REG_SUBNET_MASK) mask = data;
            else if (idx == REG_GATEWAY_IP) gateway = data;
        endfunction

        function void note_request(logic act, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
            resolution_t      res;
            int               slot;
            logic [IP_W-1:0]  hop;
            res = '0;
            if (act == ACT_LEARN) begin
                res.next_hop = ip;
                slot = find_slot(ip);
                if (slot >= 0) begin
                    mac_tab[slot] = mac;
                    res.hit       = 1'b1;
                    res.mac_out   = mac;
                end else if (in_use < TABLE_DEPTH) begin
                    ip_tab[in_use]  = ip;
                    mac_tab[in_use] = mac;
                    in_use++;
                end else begin
                    res.table_full = 1'b1;
                end
            end else begin
                hop = ((ip & mask) == (gateway & mask)) ? ip : gateway;
                res.next_hop = hop;
                slot = find_slot(hop);
                if (slot >= 0) begin
                    res.hit     = 1'b1;
                    res.mac_out = mac_tab[slot];
                end
            end
            awaited.push_back(res);
        endfunction

        function void compare_field(string label, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic hit, logic [IP_W-1:0] hop, logic [MAC_W-1:0] mac,
                                   logic full);
            resolution_t want;
            if (awaited.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, got hit=%b hop=%h",
                         $time, hit, hop);
                failures++;
                return;
            end
            want = awaited.pop_front();
            compare_field("hit", 64'(want.hit), 64'(hit));
            compare_field("next_hop", 64'(want.next_hop), 64'(hop));
            compare_field("mac_out", 64'(want.mac_out), 64'(mac));
            compare_field("table_full", 64'(want.table_full), 64'(full));
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_action;
    logic [IP_W-1:0]      s_ip_addr;
    logic [MAC_W-1:0]     s_mac_addr;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_hit;
    logic [IP_W-1:0]      m_next_hop;
    logic [MAC_W-1:0]     m_mac_out;
    logic                 m_table_full;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [IP_W-1:0]      cfg_data;

    resolution_book       book;
    longint               cycles = 0;
    // When set, the request side sends back to back without gaps.
    bit                   src_steady = 0;
    logic [IP_W-1:0]      addr_pool [POOL_SIZE];

    ip_neighbor_table_resolver_top #(
        .ENTRIES (TABLE_DEPTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_ip_addr    (s_ip_addr),
        .s_mac_addr   (s_mac_addr),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit),
        .m_next_hop   (m_next_hop),
        .m_mac_out    (m_mac_out),
        .m_table_full (m_table_full),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Results are sampled at the rising edge, so the values seen are those
    // that were stable before the edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            book.check_result(m_hit, m_next_hop, m_mac_out, m_table_full);
        end
    end

    // Result-side back-pressure. The receiver is mostly ready, stalls now and then,
    // sometimes for a long hold, and in some stretches it never stalls at all.
    initial begin
        int hold;
        int since;
        int r;
        bit steady;
        hold   = 0;
        since  = 0;
        steady = 0;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            since++;
            if (since >= 300) begin
                since  = 0;
                steady = ($urandom_range(0, 3) == 0);
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (steady) begin
                m_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    m_ready <= 1'b1;
                end else if (r < 96) begin
                    hold = $urandom_range(0, 2);
                    m_ready <= 1'b0;
                end else begin
                    hold = $urandom_range(8, 60);
                    m_ready <= 1'b0;
                end
            end
        end
    end

    // Idle cycles to leave before the next request.
    function automatic int pick_gap();
        int r;
        if (src_steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Presents one request from a falling edge and holds it until it is
    // accepted. The request is noted with the predictor at the accepting edge.
    // Valid is left high when no gap follows; the caller lowers it when the
    // stream of requests ends.
    task automatic send_request(input logic act, input logic [IP_W-1:0] ip,
                                input logic [MAC_W-1:0] mac);
        int gap;
        s_valid    <= 1'b1;
        s_action   <= act;
        s_ip_addr  <= ip;
        s_mac_addr <= mac;
        do @(posedge aclk); while (!s_ready);
        book.note_request(act, ip, mac);
        @(negedge aclk);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Stops sending and waits until every outstanding result has come back
    // and the block has had time to go idle.
    task automatic settle();
        s_valid <= 1'b0;
        while (book.outstanding() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // One register write; it is only issued while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IP_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        book.set_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        logic [IP_W-1:0]  phase_mask [PHASES];
        logic [IP_W-1:0]  phase_gw [PHASES];
        logic [IP_W-1:0]  cur_mask;
        logic [IP_W-1:0]  cur_gw;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic             act;
        int               lim;
        int               r;

        book = new();

        // Every input is at a known value from time zero.
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_action   = ACT_LEARN;
        s_ip_addr  = '0;
        s_mac_addr = '0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_SUBNET_MASK;
        cfg_data   = '0;

        // Address pool for learning and resolving. It is larger than the
        // table, so the table fills up gradually as later phases draw on
        // more of it, and eventually learns of new addresses are refused.
        addr_pool[0] = 32'hC0A8_0101;
        for (int i = 1; i < 8; i++) addr_pool[i] = {24'hC0A801, 8'($urandom)};
        for (int i = 8; i < 12; i++) addr_pool[i] = {16'hC0A8, 16'($urandom)};
        for (int i = 12; i < 14; i++) addr_pool[i] = {24'h0A0000, 8'($urandom)};
        for (int i = 14; i < 22; i++) addr_pool[i] = $urandom;
        addr_pool[22] = 32'h0A00_0001;
        addr_pool[23] = 32'h0000_0001;

        // Routing settings of the random phases, the extremes among them.
        // Phase 4 gets a random prefix length and gateway at run time.
        phase_mask[0] = 32'hFFFF_FF00;  phase_gw[0] = 32'hC0A8_0101;
        phase_mask[1] = 32'hFFFF_0000;  phase_gw[1] = 32'hC0A8_0101;
        phase_mask[2] = 32'h0000_0000;  phase_gw[2] = 32'h0A00_0001;
        phase_mask[3] = 32'hFFFF_FFFF;  phase_gw[3] = 32'hC0A8_0101;
        phase_mask[4] = {IP_W{1'b1}} << (IP_W - $urandom_range(0, IP_W));
        phase_gw[4]   = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        phase_mask[5] = 32'hFFFF_FF00;  phase_gw[5] = BCAST_IP;
        phase_mask[6] = 32'hFFFF_FFF0;  phase_gw[6] = 32'hC0A8_0101;

        // Synchronous reset, held low and then released once.
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed requests with the reset routing (mask /24, gateway 0).
        // Broadcast is off-subnet here, so it routes to gateway 0: a miss.
        send_request(ACT_RESOLVE, BCAST_IP, '0);
        // An on-subnet destination that is not in the table.
        send_request(ACT_RESOLVE, 32'h0000_0005, BCAST_MAC);
        // Learn address zero with an all-zero MAC: a new entry.
        send_request(ACT_LEARN, 32'h0000_0000, 48'h0);
        // Off-subnet destination goes to gateway 0, which is now known.
        send_request(ACT_RESOLVE, 32'hC0A8_0101, 48'h0);
        // Learning broadcast overwrites the MAC of entry 0, then restores it.
        send_request(ACT_LEARN, BCAST_IP, 48'h1234_5678_9ABC);
        send_request(ACT_LEARN, BCAST_IP, BCAST_MAC);
        // Re-learning a present address replaces its MAC and reports a hit.
        send_request(ACT_LEARN, 32'h0000_0000, BCAST_MAC);
        send_request(ACT_RESOLVE, 32'h0000_00FF, 48'h0);
        send_request(ACT_LEARN, 32'h0000_00FF, 48'h0000_0000_0001);
        send_request(ACT_RESOLVE, 32'h0000_00FF, 48'h0);
        send_request(ACT_RESOLVE, 32'h0000_0042, 48'h0);

        // Gateway set to broadcast: broadcast itself is on-subnet, and any
        // off-subnet destination resolves to the broadcast MAC.
        settle();
        write_reg(REG_GATEWAY_IP, BCAST_IP);
        send_request(ACT_RESOLVE, BCAST_IP, 48'h0);
        send_request(ACT_RESOLVE, 32'hFFFF_FF42, 48'h0);
        send_request(ACT_RESOLVE, 32'h0102_0304, 48'h0);

        // Random phases, each under its own routing setting. Most requests
        // use pool addresses so that learns and resolves meet in the table.
        for (int p = 0; p < PHASES; p++) begin
            settle();
            cur_mask = phase_mask[p];
            cur_gw   = phase_gw[p];
            write_reg(REG_SUBNET_MASK, cur_mask);
            write_reg(REG_GATEWAY_IP, cur_gw);
            // A write to an unused index must change nothing.
            write_reg(REG_SPARE_BASE + 8'($urandom_range(0, 253)), $urandom);
            lim = 6 + 3 * p;
            if (lim > POOL_SIZE - 1) lim = POOL_SIZE - 1;

            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                if (n % 32 == 0) src_steady = ($urandom_range(0, 3) == 0);
                mac = {16'($urandom), 32'($urandom)};
                r   = $urandom_range(0, 99);
                if (r < 45) begin
                    act = ACT_LEARN;
                    ip  = addr_pool[$urandom_range(0, lim)];
                end else if (r < 70) begin
                    act = ACT_RESOLVE;
                    ip  = addr_pool[$urandom_range(0, lim)];
                end else if (r < 85) begin
                    // A random host on the gateway's subnet.
                    act = ACT_RESOLVE;
                    ip  = (cur_gw & cur_mask) | (32'($urandom) & ~cur_mask);
                end else begin
                    act = ACT_RESOLVE;
                    ip  = $urandom;
                end
                send_request(act, ip, mac);
            end
        end

        settle();
        if (book.failures == 0 && book.outstanding() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> ip_neighbor_table_resolver_top.f
hw/rtl/iptr_pkg.sv
hw/rtl/iptr_ctrl.sv
hw/rtl/iptr_dp.sv
hw/rtl/ip_neighbor_table_resolver_top.sv
verif/ip_neighbor_table_resolver_top_test.sv
